@@ rtl/core/nais_pkg.sv @@
// Shared types and constants for the nearest atom index selector.
// Used by the sorting cells and the top level; depends on nothing else.
package nais_pkg;

    localparam int DIMS_DEF          = 16;
    localparam int ATOMS_DEF         = 256;
    localparam int MAX_NEIGHBORS_DEF = 16;

    localparam int DIST_W = 32;

    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } t_cell_ctl;

endpackage

@@ rtl/core/nearest_atom_index_selector.sv @@
// A query reads n atoms, where n is the atom count in use, from the table RAM one per cycle,
// registers each distance and inserts it in the cell chain; k indices then follow one per
// cycle unless stalled. Input stalls until the last index; while idle, one load per cycle.
// Reset (synchronous, active low) clears control state and sets atoms_used to 256 and
// neighbors_used to 16; the atom table is undefined until written.
// Depends on nais_pkg, nais_ram and nais_cell.
module nearest_atom_index_selector #(
    parameter int DIMS          = nais_pkg::DIMS_DEF,
    parameter int ATOMS         = nais_pkg::ATOMS_DEF,
    parameter int MAX_NEIGHBORS = nais_pkg::MAX_NEIGHBORS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_in_command,
    input  logic [3:0]  i_in_dimension,
    input  logic [7:0]  i_in_atom_index,
    input  logic [31:0] i_in_sample_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_neighbor_index,
    output logic [3:0]  o_out_rank,
    output logic        o_out_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import nais_pkg::*;

    localparam int AIW = (ATOMS > 1) ? $clog2(ATOMS) : 1;
    localparam int CW  = $clog2(ATOMS + 1);
    localparam int AW  = $clog2(DIMS * ATOMS);
    localparam int KW  = $clog2(MAX_NEIGHBORS + 1);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic REG_ATOMS_USED     = 1'b0;
    localparam logic REG_NEIGHBORS_USED = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [8:0]  r_atoms_used;
    logic [4:0]  r_neighbors_used;
    logic [3:0]  r_dim;
    logic [31:0] r_query;
    logic [CW-1:0] r_n_atoms;
    logic [KW-1:0] r_k;
    logic [CW-1:0] r_issue_cnt;
    logic [KW-1:0] r_emit_cnt;

    logic            r_s1_vld;
    logic [AIW-1:0]  r_s1_idx;
    logic            r_s2_vld;
    logic [DIST_W-1:0] r_s2_dist;
    logic [AIW-1:0]  r_s2_idx;

    logic        w_in_acc;
    logic        w_dim_ok;
    logic        w_idx_ok;
    logic        w_start;
    logic        w_issue;
    logic        w_scan_done;
    logic        w_emit;
    logic        w_emit_last;
    logic        w_cfg_wr;
    logic [31:0] w_n_atoms32;
    logic [31:0] w_k32;
    logic [KW-1:0] w_k;
    logic        w_we;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [31:0] w_rdata;
    logic [32:0] w_a_ext;
    logic [32:0] w_q_ext;
    logic [32:0] w_diff_aq;
    logic [32:0] w_diff_qa;
    logic [DIST_W-1:0] w_dist;
    t_cell_ctl   w_ctl;

    logic              w_before   [MAX_NEIGHBORS];
    logic              w_vld      [MAX_NEIGHBORS];
    logic [DIST_W-1:0] w_cdist    [MAX_NEIGHBORS];
    logic [AIW-1:0]    w_cidx     [MAX_NEIGHBORS];
    logic              w_pbefore  [MAX_NEIGHBORS];
    logic              w_pvld     [MAX_NEIGHBORS];
    logic [DIST_W-1:0] w_pdist    [MAX_NEIGHBORS];
    logic [AIW-1:0]    w_pidx     [MAX_NEIGHBORS];
    logic              w_nvld     [MAX_NEIGHBORS];
    logic [DIST_W-1:0] w_ndist    [MAX_NEIGHBORS];
    logic [AIW-1:0]    w_nidx     [MAX_NEIGHBORS];

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            REG_ATOMS_USED:     prdata = 32'(r_atoms_used);
            REG_NEIGHBORS_USED: prdata = 32'(r_neighbors_used);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atoms_used     <= 9'd256;
            r_neighbors_used <= 5'd16;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_ATOMS_USED:     r_atoms_used     <= pwdata[8:0];
                REG_NEIGHBORS_USED: r_neighbors_used <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // Input side.
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_dim_ok   = 32'(i_in_dimension) < 32'(DIMS);
    assign w_idx_ok   = 32'(i_in_atom_index) < 32'(ATOMS);

    assign w_n_atoms32 = (32'(r_atoms_used) > 32'(ATOMS)) ? 32'(ATOMS) : 32'(r_atoms_used);

    always_comb begin
        w_k32 = (32'(r_neighbors_used) > 32'(MAX_NEIGHBORS)) ? 32'(MAX_NEIGHBORS)
                                                             : 32'(r_neighbors_used);
        if (w_k32 > w_n_atoms32) begin
            w_k32 = w_n_atoms32;
        end
    end
    assign w_k = KW'(w_k32);

    assign w_start = w_in_acc && (i_in_command == CMD_QUERY) && w_dim_ok && (w_k32 != 32'd0);

    // Atom table.
    assign w_we    = w_in_acc && (i_in_command == CMD_LOAD) && w_dim_ok && w_idx_ok;
    assign w_waddr = AW'(i_in_dimension) * AW'(ATOMS) + AW'(i_in_atom_index);
    assign w_raddr = AW'(r_dim) * AW'(ATOMS) + AW'(r_issue_cnt[AIW-1:0]);

    nais_ram #(
        .WIDTH (32),
        .DEPTH (DIMS * ATOMS)
    ) u_atom_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in_sample_value),
        .i_re    (w_issue),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Scan pipeline: read, distance, insert.
    assign w_issue     = (r_state == S_SCAN) && (r_issue_cnt < r_n_atoms);
    assign w_scan_done = (r_state == S_SCAN) && (r_issue_cnt == r_n_atoms)
                         && !r_s1_vld && !r_s2_vld;

    assign w_a_ext   = {w_rdata[31], w_rdata};
    assign w_q_ext   = {r_query[31], r_query};
    assign w_diff_aq = w_a_ext - w_q_ext;
    assign w_diff_qa = w_q_ext - w_a_ext;
    assign w_dist    = w_diff_aq[32] ? w_diff_qa[DIST_W-1:0] : w_diff_aq[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_issue;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx  <= r_issue_cnt[AIW-1:0];
        r_s2_dist <= w_dist;
        r_s2_idx  <= r_s1_idx;
    end

    // Sequencer.
    assign w_emit      = (r_state == S_EMIT) && (!o_out_valid || !i_out_stall);
    assign w_emit_last = (r_emit_cnt == KW'(r_k - KW'(1)));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_emit && w_emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue_cnt <= '0;
            r_emit_cnt  <= '0;
        end else begin
            r_state <= n_state;
            if (w_start) begin
                r_issue_cnt <= '0;
            end else if (w_issue) begin
                r_issue_cnt <= r_issue_cnt + CW'(1);
            end
            if (w_scan_done) begin
                r_emit_cnt <= '0;
            end else if (w_emit) begin
                r_emit_cnt <= r_emit_cnt + KW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_dim     <= i_in_dimension;
            r_query   <= i_in_sample_value;
            r_n_atoms <= CW'(w_n_atoms32);
            r_k       <= w_k;
        end
    end

    // Chain of sorting cells.
    assign w_ctl.clear  = w_start;
    assign w_ctl.insert = r_s2_vld;
    assign w_ctl.shift  = w_emit;

    for (genvar j = 0; j < MAX_NEIGHBORS; j++) begin : g_cell
        if (j == 0) begin : g_head
            assign w_pbefore[j] = 1'b0;
            assign w_pvld[j]    = 1'b0;
            assign w_pdist[j]   = '0;
            assign w_pidx[j]    = '0;
        end else begin : g_body
            assign w_pbefore[j] = w_before[j-1];
            assign w_pvld[j]    = w_vld[j-1];
            assign w_pdist[j]   = w_cdist[j-1];
            assign w_pidx[j]    = w_cidx[j-1];
        end
        if (j == MAX_NEIGHBORS - 1) begin : g_tail
            assign w_nvld[j]  = 1'b0;
            assign w_ndist[j] = '0;
            assign w_nidx[j]  = '0;
        end else begin : g_link
            assign w_nvld[j]  = w_vld[j+1];
            assign w_ndist[j] = w_cdist[j+1];
            assign w_nidx[j]  = w_cidx[j+1];
        end

        nais_cell #(
            .IW (AIW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_cand_dist   (r_s2_dist),
            .i_cand_idx    (r_s2_idx),
            .i_prev_before (w_pbefore[j]),
            .i_prev_vld    (w_pvld[j]),
            .i_prev_dist   (w_pdist[j]),
            .i_prev_idx    (w_pidx[j]),
            .i_next_vld    (w_nvld[j]),
            .i_next_dist   (w_ndist[j]),
            .i_next_idx    (w_nidx[j]),
            .o_before      (w_before[j]),
            .o_vld         (w_vld[j]),
            .o_dist        (w_cdist[j]),
            .o_idx         (w_cidx[j])
        );
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_emit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_out_neighbor_index <= 8'(w_cidx[0]);
            o_out_rank           <= 4'(r_emit_cnt);
            o_out_last           <= w_emit_last;
        end
    end

`ifndef SYNTH
    a_emit_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> w_vld[0])
        else $error("Emitting from an empty cell chain.");

    a_pipe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld || r_s2_vld) |-> (r_state == S_SCAN))
        else $error("Scan pipeline busy outside the scan.");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_issue_cnt <= r_n_atoms))
        else $error("Atom read counter ran past the atom count.");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_emit_cnt < r_k))
        else $error("More indices emitted than requested.");

    for (genvar j = 0; j < MAX_NEIGHBORS - 1; j++) begin : g_chk
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            w_vld[j+1] |-> (w_vld[j] && (w_cdist[j] <= w_cdist[j+1])))
            else $error("Cell chain out of distance order.");
    end
`endif

endmodule

@@ rtl/core/nais_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; holds the atom table of the selector.
module nais_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ rtl/core/nais_cell.sv @@
// One cell of the sorted insertion chain: holds one distance and atom index.
// Depends on nais_pkg for the distance width and the control struct.
module nais_cell #(
    parameter int IW = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  nais_pkg::t_cell_ctl        i_ctl,
    input  logic [nais_pkg::DIST_W-1:0] i_cand_dist,
    input  logic [IW-1:0]              i_cand_idx,
    input  logic                       i_prev_before,
    input  logic                       i_prev_vld,
    input  logic [nais_pkg::DIST_W-1:0] i_prev_dist,
    input  logic [IW-1:0]              i_prev_idx,
    input  logic                       i_next_vld,
    input  logic [nais_pkg::DIST_W-1:0] i_next_dist,
    input  logic [IW-1:0]              i_next_idx,
    output logic                       o_before,
    output logic                       o_vld,
    output logic [nais_pkg::DIST_W-1:0] o_dist,
    output logic [IW-1:0]              o_idx
);
    import nais_pkg::*;

    logic              r_vld;
    logic [DIST_W-1:0] r_dist;
    logic [IW-1:0]     r_idx;

    // A candidate goes ahead of a valid entry only when strictly nearer, or takes an empty one,
    // so ties keep the lower index in front.
    assign o_before = !r_vld || (i_cand_dist < r_dist);
    assign o_vld    = r_vld;
    assign o_dist   = r_dist;
    assign o_idx    = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.clear) begin
            r_vld <= 1'b0;
        end else if (i_ctl.shift) begin
            r_vld <= i_next_vld;
        end else if (i_ctl.insert) begin
            if (i_prev_before) begin
                r_vld <= i_prev_vld;
            end else if (o_before) begin
                r_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_dist <= i_next_dist;
            r_idx  <= i_next_idx;
        end else if (i_ctl.insert) begin
            if (i_prev_before) begin
                r_dist <= i_prev_dist;
                r_idx  <= i_prev_idx;
            end else if (o_before) begin
                r_dist <= i_cand_dist;
                r_idx  <= i_cand_idx;
            end
        end
    end

endmodule
